FILE: design/slic_pkg.sv
`default_nettype none
package slic_pkg;

  localparam int MAX_LEN  = 1024;
  localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int MATCH_W  = 11;
  localparam int ACCESS_W = 12;

  localparam logic [MATCH_W-1:0]  MATCH_MAX  = {MATCH_W{1'b1}};
  localparam logic [ACCESS_W-1:0] ACCESS_MAX = {ACCESS_W{1'b1}};
  localparam logic [LEN_W-1:0]    LEN_FULL   = LEN_W'(MAX_LEN);

  // command codes carried in s_tuser
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;     // reset walk indices and counts
    logic step;      // one merge step
    logic finish;    // capture walk counts, empty lists
    logic zero_res;  // capture zero counts, empty lists
  } slic_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic early_exit;  // a list empty or ranges disjoint
    logic walk_done;   // this step reaches the end of a list
  } slic_stat_t;

endpackage
`default_nettype wire

FILE: design/slic_controller.sv
`default_nettype none
module slic_controller (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [slic_pkg::CMD_W-1:0] cmd,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  input  slic_pkg::slic_stat_t      stat,
  output slic_pkg::slic_cmd_t       ctl
);
  import slic_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   run;

  // result register must be free (or draining) before any new beat
  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign run      = accept && (cmd == CMD_RUN);

  always_comb begin
    ctl          = '0;
    ctl.load_a   = accept && (cmd == CMD_LOAD_A);
    ctl.load_b   = accept && (cmd == CMD_LOAD_B);
    ctl.start    = run && !stat.early_exit;
    ctl.zero_res = run && stat.early_exit;
    ctl.step     = (state == ST_WALK);
    ctl.finish   = (state == ST_WALK) && stat.walk_done;
    state_next   = state;
    unique case (state)
      ST_IDLE: begin
        if (ctl.start) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (stat.walk_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.finish || ctl.zero_res) m_tvalid <= 1'b1;
      else if (m_tready)              m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: design/slic_datapath.sv
`default_nettype none
module slic_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [slic_pkg::VALUE_W-1:0] value,
  input  slic_pkg::slic_cmd_t                ctl,
  output slic_pkg::slic_stat_t               stat,
  output logic [slic_pkg::MATCH_W-1:0]       res_match,
  output logic [slic_pkg::ACCESS_W-1:0]      res_access,
  output logic                               res_ovf
);
  import slic_pkg::*;

  logic signed [VALUE_W-1:0] mem_a [MAX_LEN];
  logic signed [VALUE_W-1:0] mem_b [MAX_LEN];

  logic [LEN_W-1:0]          len_a, len_b;
  logic                      ovf_flag;
  logic signed [VALUE_W-1:0] first_a, last_a, first_b, last_b;
  logic                      full_a, full_b;

  logic [LEN_W-1:0]          ia, ib, ia_next, ib_next;
  logic [MATCH_W-1:0]        mcnt, mcnt_next;
  logic [ACCESS_W-1:0]       acnt, acnt_next;
  logic signed [VALUE_W-1:0] head_a, head_b;
  logic                      heads_eq, a_lt_b;

  assign full_a = (len_a == LEN_FULL);
  assign full_b = (len_b == LEN_FULL);

  assign stat.early_exit = (len_a == '0) || (len_b == '0) ||
                           (last_a < first_b) || (last_b < first_a);

  // lengths, range bounds, drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      len_a    <= '0;
      len_b    <= '0;
      ovf_flag <= 1'b0;
    end else if (ctl.finish || ctl.zero_res) begin
      len_a    <= '0;
      len_b    <= '0;
      ovf_flag <= 1'b0;
    end else begin
      if (ctl.load_a) begin
        if (full_a) ovf_flag <= 1'b1;
        else        len_a    <= len_a + LEN_W'(1);
      end
      if (ctl.load_b) begin
        if (full_b) ovf_flag <= 1'b1;
        else        len_b    <= len_b + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_a && !full_a) begin
      if (len_a == '0) first_a <= value;
      last_a <= value;
    end
    if (ctl.load_b && !full_b) begin
      if (len_b == '0) first_b <= value;
      last_b <= value;
    end
  end

  // list memories: one write, one registered read each; read address is the
  // next walk index so the head is ready in the step that uses it
  always_ff @(posedge clk) begin
    if (ctl.load_a && !full_a) mem_a[len_a[ADDR_W-1:0]] <= value;
    head_a <= mem_a[ia_next[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_b && !full_b) mem_b[len_b[ADDR_W-1:0]] <= value;
    head_b <= mem_b[ib_next[ADDR_W-1:0]];
  end

  assign heads_eq = (head_a == head_b);
  assign a_lt_b   = (head_a < head_b);

  // merge step
  always_comb begin
    ia_next   = ia;
    ib_next   = ib;
    mcnt_next = mcnt;
    acnt_next = acnt;
    if (ctl.start) begin
      ia_next   = '0;
      ib_next   = '0;
      mcnt_next = '0;
      acnt_next = '0;
    end else if (ctl.step) begin
      if (heads_eq) begin
        ia_next   = ia + LEN_W'(1);
        ib_next   = ib + LEN_W'(1);
        mcnt_next = (mcnt == MATCH_MAX) ? mcnt : mcnt + MATCH_W'(1);
        acnt_next = (acnt >= ACCESS_MAX - ACCESS_W'(1)) ? ACCESS_MAX
                                                         : acnt + ACCESS_W'(2);
      end else begin
        if (a_lt_b) ia_next = ia + LEN_W'(1);
        else        ib_next = ib + LEN_W'(1);
        acnt_next = (acnt == ACCESS_MAX) ? acnt : acnt + ACCESS_W'(1);
      end
    end
  end

  assign stat.walk_done = (ia_next == len_a) || (ib_next == len_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      ia   <= '0;
      ib   <= '0;
      mcnt <= '0;
      acnt <= '0;
    end else begin
      ia   <= ia_next;
      ib   <= ib_next;
      mcnt <= mcnt_next;
      acnt <= acnt_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      res_match  <= mcnt_next;
      res_access <= acnt_next;
      res_ovf    <= ovf_flag;
    end else if (ctl.zero_res) begin
      res_match  <= '0;
      res_access <= '0;
      res_ovf    <= ovf_flag;
    end
  end

endmodule
`default_nettype wire

FILE: design/sorted_list_intersection_count_unit.sv
// Sorted-list intersection counter.
// Input stream (s_*): one beat per command. s_tuser = cmd (0 load A, 1 load B,
// 2 run, 3 ignored), s_tdata = value to append (signed 32 bit).
// Output stream (m_*): one beat per run, none for loads.
// A run on an empty list or on lists whose value ranges do not overlap posts a
// zero result at the accept edge (visible the next cycle). Otherwise the merge
// walk does one step per cycle, N steps with N <= len_a + len_b, set by the
// single registered read port of each list memory; the result shows the cycle
// after the last step. No beat is taken during a walk.
// After a result is posted both lists and the overflow flag are emptied.
// If the receiver stalls, the result holds in the output register and s_tready
// stays low until it is taken (a taken result frees the slot the same cycle).
// Reset (rst, synchronous) empties both lists, clears overflow and drops any
// pending result. List memories are never cleared; only written entries are used
// by the walk.
`default_nettype none
module sorted_list_intersection_count_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [10:0] match_count, [22:11] access_count,
                                 // [23] overflow
);
  import slic_pkg::*;

  slic_cmd_t           ctl;
  slic_stat_t          stat;
  logic [MATCH_W-1:0]  res_match;
  logic [ACCESS_W-1:0] res_access;
  logic                res_ovf;

  slic_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  slic_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      ($signed(s_tdata)),
    .ctl        (ctl),
    .stat       (stat),
    .res_match  (res_match),
    .res_access (res_access),
    .res_ovf    (res_ovf)
  );

  assign m_tdata = {res_ovf, res_access, res_match};

`ifndef NO_ASSERTIONS
  // no input beat is taken while the walk is running
  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> !s_tready)
    else $error("input accepted during walk");

  // posting a result empties the lists
  a_lists_emptied: assert property (@(posedge clk) disable iff (rst)
    (ctl.finish || ctl.zero_res) |=> stat.early_exit)
    else $error("lists not emptied after result");

  // every match costs two reads
  a_count_relation: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, res_match} << 1) <= res_access)
    else $error("access count below twice match count");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_intersect_pkg.sv
`timescale 1ns / 1ps
package tb_intersect_pkg;
  import slic_pkg::*;

  // cmd value that the block ignores
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [MATCH_W-1:0]  hits;
    logic [ACCESS_W-1:0] reads;
    logic                ovf;
  } count_result_t;

  class intersect_scoreboard;
    logic signed [VALUE_W-1:0] list_a [MAX_LEN];
    logic signed [VALUE_W-1:0] list_b [MAX_LEN];
    int unsigned len_a, len_b;
    bit dropped;
    count_result_t expected_q[$];
    int unsigned errors, runs, loads, ignored, drop_runs, hit_runs, longest;

    // merge walk over the lists as they stand now
    function count_result_t predict_run();
      int unsigned ia, ib, hits, reads;
      count_result_t res;
      ia = 0;
      ib = 0;
      hits = 0;
      reads = 0;
      res.ovf = dropped;
      if (len_a != 0 && len_b != 0 &&
          !(list_a[len_a-1] < list_b[0]) && !(list_b[len_b-1] < list_a[0])) begin
        while (ia < len_a && ib < len_b) begin
          if (list_a[ia] == list_b[ib]) begin
            ia++;
            ib++;
            hits++;
            reads += 2;
          end else if (list_a[ia] < list_b[ib]) begin
            ia++;
            reads++;
          end else begin
            ib++;
            reads++;
          end
        end
      end
      res.hits  = (hits > MATCH_MAX) ? MATCH_MAX : hits[MATCH_W-1:0];
      res.reads = (reads > ACCESS_MAX) ? ACCESS_MAX : reads[ACCESS_W-1:0];
      return res;
    endfunction

    function void note_beat(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val);
      case (cmd)
        CMD_LOAD_A: begin
          loads++;
          if (len_a >= MAX_LEN) dropped = 1'b1;
          else begin
            list_a[len_a] = val;
            len_a++;
          end
        end
        CMD_LOAD_B: begin
          loads++;
          if (len_b >= MAX_LEN) dropped = 1'b1;
          else begin
            list_b[len_b] = val;
            len_b++;
          end
        end
        CMD_RUN: begin
          count_result_t res;
          res = predict_run();
          expected_q.push_back(res);
          runs++;
          if (dropped) drop_runs++;
          if (res.hits != 0) hit_runs++;
          if (len_a > longest) longest = len_a;
          if (len_b > longest) longest = len_b;
          len_a = 0;
          len_b = 0;
          dropped = 1'b0;
        end
        default: ignored++;
      endcase
    endfunction

    function void check_result(logic [MATCH_W+ACCESS_W:0] data);
      count_result_t got, want;
      got.hits  = data[MATCH_W-1:0];
      got.reads = data[MATCH_W+ACCESS_W-1:MATCH_W];
      got.ovf   = data[MATCH_W+ACCESS_W];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: result beat with no run pending: hits=%0d reads=%0d ovf=%0b",
                   $realtime, got.hits, got.reads, got.ovf);
      end else begin
        want = expected_q.pop_front();
        if (got.hits !== want.hits || got.reads !== want.reads || got.ovf !== want.ovf) begin
          errors++;
          if (errors <= 10)
            $display("ERROR %0t: hits exp %0d got %0d, reads exp %0d got %0d, ovf exp %0b got %0b",
                     $realtime, want.hits, got.hits, want.reads, got.reads, want.ovf, got.ovf);
        end
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function void close_out();
      if (expected_q.size() != 0) begin
        errors += expected_q.size();
        $display("ERROR: %0d runs never produced a result", expected_q.size());
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import slic_pkg::*;
  import tb_intersect_pkg::*;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [31:0] s_tdata;   // [31:0] value
  logic [1:0] s_tuser;    // [1:0] cmd
  logic m_tvalid;
  logic m_tready;
  logic [23:0] m_tdata;   // [10:0] match_count, [22:11] access_count, [23] overflow

  intersect_scoreboard sb = new();

  // sender side: calm sets go back-to-back with no gaps
  bit calm_tx;
  // long receiver hold-off, requested by the stimulus, counted by its own process
  bit hold_go;
  logic stall_hold = 1'b0;
  int unsigned beats_sent;

  sorted_list_intersection_count_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog: ends a hung run and reports it as an error
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_tx) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One input beat. tvalid is only dropped when a gap follows, so a valid
  // that stays high never sees two assignments in one step.
  task automatic send_beat(input logic [1:0] cmd, input logic [31:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
    sb.note_beat(cmd, val);
    if (cmd != CMD_NOP) beats_sent++;
  endtask

  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 12);
    return $urandom_range(13, 40);
  endfunction

  // bases spread over the whole range, around zero and at both extremes
  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: return 32'($urandom_range(0, 40)) - 32'd20;
      default: begin
        if ($urandom_range(0, 1)) return 32'h8000_0000 + 32'($urandom_range(0, 20));
        return 32'h7FFF_FFFF - 32'($urandom_range(0, 60));
      end
    endcase
  endfunction

  // ascending run; step 0 gives duplicates
  function automatic void fill_rising(ref logic [31:0] q[$], input logic [31:0] start,
                                      input int n);
    logic [31:0] v;
    v = start;
    for (int i = 0; i < n; i++) begin
      q.push_back(v);
      v = v + 32'($urandom_range(0, 3));
    end
  endfunction

  // One random set: build both lists, interleave the loads (with the odd
  // ignored beat thrown in), then run.
  task automatic play_set();
    logic [31:0] qa[$];
    logic [31:0] qb[$];
    logic [31:0] tmp[$];
    logic [31:0] base;
    int kind, na, nb;
    bit do_run;
    kind = $urandom_range(0, 99);
    base = pick_base();
    na = pick_len();
    nb = pick_len();
    do_run = 1'b1;
    calm_tx = ($urandom_range(0, 4) == 0);
    if (kind < 65) begin
      // overlapping ranges, many shared values
      fill_rising(qa, base, na);
      fill_rising(qb, base + 32'($urandom_range(0, 4)), nb);
    end else if (kind < 78) begin
      // disjoint ranges, either order
      fill_rising(qa, base, na);
      fill_rising(qb, (na > 0 ? qa[$] : base) + 32'd1 + 32'($urandom_range(0, 5)), nb);
      if ($urandom_range(0, 1)) begin
        tmp = qa;
        qa = qb;
        qb = tmp;
      end
    end else if (kind < 88) begin
      // unsorted content, small signed values
      for (int i = 0; i < na; i++) qa.push_back(32'($urandom_range(0, 15)) - 32'd8);
      for (int i = 0; i < nb; i++) qb.push_back(32'($urandom_range(0, 15)) - 32'd8);
    end else begin
      // noise: any command, any value, run only sometimes
      repeat ($urandom_range(1, 8)) send_beat(2'($urandom_range(0, 3)), $urandom);
      do_run = $urandom_range(0, 1);
    end
    while (qa.size() != 0 || qb.size() != 0) begin
      if ($urandom_range(0, 9) == 0) send_beat(CMD_NOP, $urandom);
      if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1)))
        send_beat(CMD_LOAD_A, qa.pop_front());
      else
        send_beat(CMD_LOAD_B, qb.pop_front());
    end
    if (do_run) send_beat(CMD_RUN, $urandom);
  endtask

  // Both lists full with the same values (largest counts), plus two loads
  // into full A that get dropped and raise the flag.
  task automatic play_full_set();
    calm_tx = 1'b1;
    for (int i = 0; i < MAX_LEN + 2; i++) send_beat(CMD_LOAD_A, 32'(3 * i) - 32'd1000);
    for (int i = 0; i < MAX_LEN; i++) send_beat(CMD_LOAD_B, 32'(3 * i) - 32'd1000);
    send_beat(CMD_RUN, 32'd0);
  endtask

  // receiver: random stalls, calm stretches, and the long hold-off
  initial begin
    int stall_left, calm_left, r;
    stall_left = 0;
    calm_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
      if (stall_hold) m_tready <= 1'b0;
      else if (calm_left > 0) begin
        calm_left--;
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          calm_left = $urandom_range(50, 150);
          m_tready <= 1'b1;
        end else if (r < 60) m_tready <= 1'b1;
        else begin
          stall_left = (r < 90) ? $urandom_range(0, 2) : $urandom_range(9, 59);
          m_tready <= 1'b0;
        end
      end
    end
  end

  // The hold-off: no result is taken while the sender keeps
  // pushing, so the output register fills and s_tready drops.
  initial begin
    wait (hold_go);
    @(posedge clk);
    stall_hold <= 1'b1;
    repeat (400) @(posedge clk);
    stall_hold <= 1'b0;
  end

  initial begin
    int unsigned target, guard;
    bit big_done;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    calm_tx = 1'b0;
    hold_go = 1'b0;
    big_done = 1'b0;
    beats_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // run with both lists empty
    send_beat(CMD_RUN, 32'hFFFF_FFFF);
    // ignored beat, then only A loaded: early exit
    send_beat(CMD_NOP, 32'h1234_5678);
    send_beat(CMD_LOAD_A, 32'h8000_0000);
    send_beat(CMD_RUN, 32'd0);
    // only B loaded
    send_beat(CMD_LOAD_B, 32'h7FFF_FFFF);
    send_beat(CMD_RUN, 32'd0);
    // A entirely below B
    send_beat(CMD_LOAD_A, -32'sd5);
    send_beat(CMD_LOAD_A, -32'sd3);
    send_beat(CMD_LOAD_B, 32'd10);
    send_beat(CMD_LOAD_B, 32'd20);
    send_beat(CMD_RUN, 32'd0);
    // B entirely below A, signed compare across zero
    send_beat(CMD_LOAD_B, 32'h8000_0000);
    send_beat(CMD_LOAD_B, 32'd0);
    send_beat(CMD_LOAD_A, 32'd100);
    send_beat(CMD_RUN, 32'd0);
    // ranges touch at the top, extremes of the value field
    send_beat(CMD_LOAD_A, 32'h8000_0000);
    send_beat(CMD_LOAD_A, 32'd7);
    send_beat(CMD_LOAD_A, 32'h7FFF_FFFF);
    send_beat(CMD_LOAD_B, 32'd7);
    send_beat(CMD_LOAD_B, 32'h7FFF_FFFF);
    send_beat(CMD_RUN, 32'd0);
    // unsorted lists with an ignored beat in the middle
    send_beat(CMD_LOAD_A, 32'd5);
    send_beat(CMD_LOAD_A, 32'd1);
    send_beat(CMD_NOP, 32'hFFFF_FFFF);
    send_beat(CMD_LOAD_B, 32'd1);
    send_beat(CMD_LOAD_B, 32'd5);
    send_beat(CMD_RUN, 32'd0);

    // --- random sets ---
    target = beats_sent + 550;
    while (beats_sent < target) begin
      if (!hold_go && beats_sent > 150) hold_go = 1'b1;
      if (!big_done && beats_sent > 300) begin
        play_full_set();
        big_done = 1'b1;
        target += 2 * MAX_LEN + 3;
      end
      play_set();
    end
    s_tvalid <= 1'b0;

    // drain, then wait for anything stray
    guard = 0;
    while (sb.outstanding() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
    sb.close_out();

    $display("Ran %0d intersections (%0d with matches, %0d with dropped loads), longest list %0d.",
             sb.runs, sb.hit_runs, sb.drop_runs, sb.longest);
    $display("Fed %0d list loads and %0d ignored beats.", sb.loads, sb.ignored);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
